// ===== rtl/fcl_pkg.sv =====
// shared types, codes and arithmetic helpers of the fully connected layer engine
package fcl_pkg;

  localparam int unsigned CNT_W = 7;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned GRD_W = 32;
  localparam int unsigned ACC_W = 40;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMIT_GRAD = 2'd2;

  localparam logic [2:0] REQ_WR_WEIGHT = 3'd0;
  localparam logic [2:0] REQ_WR_BIAS   = 3'd1;
  localparam logic [2:0] REQ_FWD_IN    = 3'd2;
  localparam logic [2:0] REQ_BWD_IN    = 3'd3;
  localparam logic [2:0] REQ_BWD_GRAD  = 3'd4;
  localparam logic [2:0] REQ_RD_GRAD   = 3'd5;
  localparam logic [2:0] REQ_CLR_GRAD  = 3'd6;

  localparam logic [1:0] KIND_FWD  = 2'd0;
  localparam logic [1:0] KIND_IGRD = 2'd1;
  localparam logic [1:0] KIND_RDBK = 2'd2;

  typedef enum logic [2:0] {
    OP_WR_WEIGHT,
    OP_WR_BIAS,
    OP_FWD_IN,
    OP_BWD_IN,
    OP_BWD_GRAD,
    OP_RD_GRAD,
    OP_CLR_GRAD,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic                    run;    // element closes the sample
    logic                    oi_ok;
    logic                    ii_ok;
    logic [IDX_W-1:0]        oi;
    logic [IDX_W-1:0]        ii;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] ni;
    logic [CNT_W-1:0] no;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic signed [GRD_W-1:0] wgrad;
    logic signed [GRD_W-1:0] bgrad;
    logic                    last;
  } res_t;

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-9:0] s;
    s = a[ACC_W-1:8];
    if (s > 32'sd32767) begin
      return 16'sh7fff;
    end else if (s < -32'sd32768) begin
      return 16'sh8000;
    end
    return s[VAL_W-1:0];
  endfunction

  function automatic logic signed [GRD_W-1:0] sat32(input logic signed [GRD_W:0] a);
    if (a[GRD_W] != a[GRD_W-1]) begin
      return a[GRD_W] ? {1'b1, {(GRD_W-1){1'b0}}} : {1'b0, {(GRD_W-1){1'b1}}};
    end
    return a[GRD_W-1:0];
  endfunction

endpackage

// ===== rtl/fcl_queue.sv =====
// small first-in first-out queue of words
module fcl_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/fcl_front.sv =====
// front end: checks and classifies incoming words and queues them for the engine
module fcl_front
  import fcl_pkg::*;
#(
  parameter int unsigned MAX_INPUTS  = 64,
  parameter int unsigned MAX_OUTPUTS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [2:0]              req_type_i,
  input  logic [IDX_W-1:0]        out_index_i,
  input  logic [IDX_W-1:0]        in_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    full_o,
  input  cfg_t                    cfg_i,
  input  logic                    cmd_pop_i,
  output cmd_t                    cmd_o,
  output logic                    cmd_valid_o
);
  cmd_t cmd_in;
  logic q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    cmd_in.oi    = out_index_i;
    cmd_in.ii    = in_index_i;
    cmd_in.value = value_i;
    cmd_in.oi_ok = ({1'b0, out_index_i} < CNT_W'(MAX_OUTPUTS));
    cmd_in.ii_ok = ({1'b0, in_index_i} < CNT_W'(MAX_INPUTS));
    cmd_in.run   = 1'b0;
    cmd_in.op    = OP_NOP;
    case (req_type_i)
      REQ_WR_WEIGHT: if (cmd_in.oi_ok && cmd_in.ii_ok) cmd_in.op = OP_WR_WEIGHT;
      REQ_WR_BIAS:   if (cmd_in.oi_ok) cmd_in.op = OP_WR_BIAS;
      REQ_FWD_IN: begin
        if (cmd_in.ii_ok) cmd_in.op = OP_FWD_IN;
        cmd_in.run = ({1'b0, in_index_i} == cfg_i.ni - 1'b1);
      end
      REQ_BWD_IN:    if (cmd_in.ii_ok) cmd_in.op = OP_BWD_IN;
      REQ_BWD_GRAD: begin
        if (cmd_in.oi_ok) cmd_in.op = OP_BWD_GRAD;
        cmd_in.run = ({1'b0, out_index_i} == cfg_i.no - 1'b1);
      end
      REQ_RD_GRAD:   cmd_in.op = OP_RD_GRAD;
      REQ_CLR_GRAD:  cmd_in.op = OP_CLR_GRAD;
      default:       cmd_in.op = OP_NOP;
    endcase
  end

  // words that change nothing are dropped here
  fcl_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(4)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && (cmd_in.op != OP_NOP)),
    .wdata_i(cmd_in),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign cmd_o       = cmd_t'(q_rdata);
  assign cmd_valid_o = !q_empty;

endmodule

// ===== rtl/fcl_back.sv =====
// back end: weight and gradient stores and the multiply-accumulate sequencer
module fcl_back
  import fcl_pkg::*;
#(
  parameter int unsigned MAX_INPUTS  = 64,
  parameter int unsigned MAX_OUTPUTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o,
  output logic                 init_busy_o,
  input  cmd_t                 cmd_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  output res_t                 res_o,
  output logic                 res_push_o,
  input  logic                 res_full_i
);
  localparam int unsigned IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int unsigned OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int unsigned AW = OW + IW;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_F_ROW  = 5'd2;
  localparam logic [4:0] S_F_BIAS = 5'd3;
  localparam logic [4:0] S_F_RD   = 5'd4;
  localparam logic [4:0] S_F_MUL  = 5'd5;
  localparam logic [4:0] S_F_ACC  = 5'd6;
  localparam logic [4:0] S_F_EMIT = 5'd7;
  localparam logic [4:0] S_B_ROW  = 5'd8;
  localparam logic [4:0] S_B_G    = 5'd9;
  localparam logic [4:0] S_B_RD   = 5'd10;
  localparam logic [4:0] S_B_MUL  = 5'd11;
  localparam logic [4:0] S_B_WR   = 5'd12;
  localparam logic [4:0] S_B_BIAS = 5'd13;
  localparam logic [4:0] S_G_COL  = 5'd14;
  localparam logic [4:0] S_G_RD   = 5'd15;
  localparam logic [4:0] S_G_MUL  = 5'd16;
  localparam logic [4:0] S_G_ACC  = 5'd17;
  localparam logic [4:0] S_G_EMIT = 5'd18;
  localparam logic [4:0] S_RB_RD  = 5'd19;
  localparam logic [4:0] S_RB_EMIT = 5'd20;

  logic [CNT_W-1:0] in_count_q, out_count_q;
  logic             emit_q;
  logic [CNT_W-1:0] ni, no;

  logic [4:0]       state_q, state_d;
  logic             init_q, init_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [CNT_W-1:0] j_q, j_d, i_q, i_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [GRD_W-1:0] prod_q, prod_d;
  logic signed [VAL_W-1:0] g_q, g_d;
  logic             oi_ok_q, oi_ok_d, ii_ok_q, ii_ok_d;

  // memories
  logic signed [VAL_W-1:0] w_mem  [2**AW];
  logic signed [GRD_W-1:0] wg_mem [2**AW];
  logic signed [VAL_W-1:0] b_mem  [2**OW];
  logic signed [GRD_W-1:0] bg_mem [2**OW];
  logic signed [VAL_W-1:0] x_mem  [2**IW];
  logic signed [VAL_W-1:0] g_mem  [2**OW];
  logic signed [VAL_W-1:0] w_rd, b_rd, x_rd, g_rd;
  logic signed [GRD_W-1:0] wg_rd, bg_rd;

  logic [AW-1:0] rd_addr, cmd_addr, wg_waddr;
  logic [OW-1:0] bg_waddr;
  logic          w_we, b_we, x_we, g_we, wg_we, bg_we;
  logic signed [GRD_W-1:0] wg_wdata, bg_wdata;
  logic          i_last, j_last;

  always_comb begin
    ni = (in_count_q == '0) ? CNT_W'(1) :
         (in_count_q > CNT_W'(MAX_INPUTS)) ? CNT_W'(MAX_INPUTS) : in_count_q;
    no = (out_count_q == '0) ? CNT_W'(1) :
         (out_count_q > CNT_W'(MAX_OUTPUTS)) ? CNT_W'(MAX_OUTPUTS) : out_count_q;
  end
  assign cfg_o.ni    = ni;
  assign cfg_o.no    = no;
  assign init_busy_o = init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  <= CNT_W'(64);
      out_count_q <= CNT_W'(64);
      emit_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IN_COUNT:  in_count_q  <= cfg_data_i;
        CFG_OUT_COUNT: out_count_q <= cfg_data_i;
        CFG_EMIT_GRAD: emit_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign rd_addr  = {j_q[OW-1:0], i_q[IW-1:0]};
  assign cmd_addr = {cmd_i.oi[OW-1:0], cmd_i.ii[IW-1:0]};
  assign i_last   = (i_q == ni - 1'b1);
  assign j_last   = (j_q == no - 1'b1);
  assign wg_waddr = (state_q == S_CLR) ? clr_q : rd_addr;
  assign bg_waddr = (state_q == S_CLR) ? clr_q[OW-1:0] : j_q[OW-1:0];

  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    clr_d     = clr_q;
    j_d       = j_q;
    i_d       = i_q;
    acc_d     = acc_q;
    prod_d    = prod_q;
    g_d       = g_q;
    oi_ok_d   = oi_ok_q;
    ii_ok_d   = ii_ok_q;
    cmd_pop_o = 1'b0;
    w_we      = 1'b0;
    b_we      = 1'b0;
    x_we      = 1'b0;
    g_we      = 1'b0;
    wg_we     = 1'b0;
    bg_we     = 1'b0;
    wg_wdata  = '0;
    bg_wdata  = '0;
    res_push_o = 1'b0;
    res_o     = '0;
    case (state_q)
      S_CLR: begin
        wg_we = 1'b1;
        bg_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          init_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_WR_WEIGHT: w_we = 1'b1;
            OP_WR_BIAS:   b_we = 1'b1;
            OP_FWD_IN: begin
              x_we = 1'b1;
              if (cmd_i.run) begin
                j_d     = '0;
                state_d = S_F_ROW;
              end
            end
            OP_BWD_IN:    x_we = 1'b1;
            OP_BWD_GRAD: begin
              g_we = 1'b1;
              if (cmd_i.run) begin
                j_d     = '0;
                state_d = S_B_ROW;
              end
            end
            OP_RD_GRAD: begin
              j_d     = {1'b0, cmd_i.oi};
              i_d     = {1'b0, cmd_i.ii};
              oi_ok_d = cmd_i.oi_ok;
              ii_ok_d = cmd_i.ii_ok;
              state_d = S_RB_RD;
            end
            OP_CLR_GRAD: begin
              clr_d   = '0;
              state_d = S_CLR;
            end
            default: ;
          endcase
        end
      end
      // forward: one output row per pass
      S_F_ROW: begin
        i_d     = '0;
        state_d = S_F_BIAS;
      end
      S_F_BIAS: begin
        acc_d   = ACC_W'(b_rd) <<< 8;
        state_d = S_F_RD;
      end
      S_F_RD:  state_d = S_F_MUL;
      S_F_MUL: begin
        prod_d  = GRD_W'(w_rd) * GRD_W'(x_rd);
        state_d = S_F_ACC;
      end
      S_F_ACC: begin
        acc_d = acc_q + ACC_W'(prod_q);
        if (i_last) begin
          state_d = S_F_EMIT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_F_RD;
        end
      end
      S_F_EMIT: begin
        res_o.kind  = KIND_FWD;
        res_o.index = j_q[IDX_W-1:0];
        res_o.value = sat16(acc_q);
        res_o.last  = j_last;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          j_d        = j_q + 1'b1;
          state_d    = j_last ? S_IDLE : S_F_ROW;
        end
      end
      // backward: gradient store update, one row per pass
      S_B_ROW: begin
        i_d     = '0;
        state_d = S_B_G;
      end
      S_B_G: begin
        g_d     = g_rd;
        state_d = S_B_RD;
      end
      S_B_RD:  state_d = S_B_MUL;
      S_B_MUL: begin
        prod_d  = GRD_W'(g_q) * GRD_W'(x_rd);
        state_d = S_B_WR;
      end
      S_B_WR: begin
        wg_we    = 1'b1;
        wg_wdata = sat32((GRD_W+1)'(wg_rd) + (GRD_W+1)'(prod_q));
        if (i_last) begin
          state_d = S_B_BIAS;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_B_RD;
        end
      end
      S_B_BIAS: begin
        bg_we    = 1'b1;
        bg_wdata = sat32((GRD_W+1)'(bg_rd) + ((GRD_W+1)'(g_q) <<< 8));
        if (j_last) begin
          i_d     = '0;
          state_d = emit_q ? S_G_COL : S_IDLE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_B_ROW;
        end
      end
      // input gradients, one column per pass
      S_G_COL: begin
        j_d     = '0;
        acc_d   = '0;
        state_d = S_G_RD;
      end
      S_G_RD:  state_d = S_G_MUL;
      S_G_MUL: begin
        prod_d  = GRD_W'(g_rd) * GRD_W'(w_rd);
        state_d = S_G_ACC;
      end
      S_G_ACC: begin
        acc_d = acc_q + ACC_W'(prod_q);
        if (j_last) begin
          state_d = S_G_EMIT;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_G_RD;
        end
      end
      S_G_EMIT: begin
        res_o.kind  = KIND_IGRD;
        res_o.index = i_q[IDX_W-1:0];
        res_o.value = sat16(acc_q);
        res_o.last  = i_last;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          i_d        = i_q + 1'b1;
          state_d    = i_last ? S_IDLE : S_G_COL;
        end
      end
      S_RB_RD: state_d = S_RB_EMIT;
      S_RB_EMIT: begin
        res_o.kind  = KIND_RDBK;
        res_o.wgrad = (oi_ok_q && ii_ok_q) ? wg_rd : '0;
        res_o.bgrad = oi_ok_q ? bg_rd : '0;
        res_o.last  = 1'b1;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      init_q  <= 1'b1;
      clr_q   <= '0;
      j_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      clr_q   <= clr_d;
      j_q     <= j_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    prod_q  <= prod_d;
    g_q     <= g_d;
    oi_ok_q <= oi_ok_d;
    ii_ok_q <= ii_ok_d;
  end

  // every store reads at the running row and column; its read data is registered
  always_ff @(posedge clk_i) begin
    w_rd <= w_mem[rd_addr];
    if (w_we) w_mem[cmd_addr] <= cmd_i.value;
  end

  always_ff @(posedge clk_i) begin
    wg_rd <= wg_mem[rd_addr];
    if (wg_we) wg_mem[wg_waddr] <= wg_wdata;
  end

  always_ff @(posedge clk_i) begin
    b_rd <= b_mem[j_q[OW-1:0]];
    if (b_we) b_mem[cmd_i.oi[OW-1:0]] <= cmd_i.value;
  end

  always_ff @(posedge clk_i) begin
    bg_rd <= bg_mem[j_q[OW-1:0]];
    if (bg_we) bg_mem[bg_waddr] <= bg_wdata;
  end

  always_ff @(posedge clk_i) begin
    x_rd <= x_mem[i_q[IW-1:0]];
    if (x_we) x_mem[cmd_i.ii[IW-1:0]] <= cmd_i.value;
  end

  always_ff @(posedge clk_i) begin
    g_rd <= g_mem[j_q[OW-1:0]];
    if (g_we) g_mem[cmd_i.oi[OW-1:0]] <= cmd_i.value;
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("result pushed into full queue");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE && !init_q)) else $error("command taken while busy");

  a_init_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(init_q) |-> (state_q == S_IDLE && $past(clr_q) == '1))
    else $error("initial clear ended early");

  a_last_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last && state_q != S_RB_EMIT) |=> state_q == S_IDLE)
    else $error("run did not end after last word");

endmodule

// ===== rtl/fully_connected_layer_engine_core.sv =====
// top level of the fully connected layer engine
// Fully connected layer in Q8.8 with Q16.16 gradient stores.
// Input channel: a word is taken when push_i is high and full_o is low.
// Result channel: the oldest result sits on the result ports while empty_o
// is low and leaves when pop_i is high.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 input
// count, 1 output count, 2 input-gradient enable); write only while idle, the
// block itself does not enforce this. The engine stores weight and bias writes
// and buffered elements. The last forward element starts a run that, for each
// output row, loads the bias and accumulates every input; the last gradient
// element starts the gradient store updates, then, if enabled, the input
// gradients. Every multiply-accumulate goes through one product register and
// one read port per store, in three steps: read, multiply, then accumulate or
// write back. A readback reads the gradient stores, then emits one word.
// A clear sweeps both gradient stores, one entry a cycle (4096 by default).
// After reset the same sweep runs and full_o stays high until it is done.
// A stalled receiver fills the two-word result queue, then the engine
// waits; the four-word command queue keeps taking words until it is full.
module fully_connected_layer_engine_core
  import fcl_pkg::*;
#(
  parameter int unsigned MAX_INPUTS  = 64,
  parameter int unsigned MAX_OUTPUTS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  logic [2:0]              req_type_i,
  input  logic [IDX_W-1:0]        out_index_i,
  input  logic [IDX_W-1:0]        in_index_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    empty_o,
  input  logic                    pop_i,
  output logic [1:0]              kind_o,
  output logic [IDX_W-1:0]        index_o,
  output logic signed [VAL_W-1:0] result_value_o,
  output logic signed [GRD_W-1:0] weight_gradient_o,
  output logic signed [GRD_W-1:0] bias_gradient_o,
  output logic                    last_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CNT_W-1:0]        cfg_data_i
);
  cfg_t cfg;
  cmd_t cmd;
  res_t res_in, res_out;
  logic cmd_valid, cmd_pop, res_push, res_full, init_busy, front_full;
  logic [$bits(res_t)-1:0] res_rdata;

  assign full_o = front_full || init_busy;

  fcl_front #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_OUTPUTS(MAX_OUTPUTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i && !init_busy),
    .req_type_i (req_type_i),
    .out_index_i(out_index_i),
    .in_index_i (in_index_i),
    .value_i    (value_i),
    .full_o     (front_full),
    .cfg_i      (cfg),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid)
  );

  fcl_back #(
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_OUTPUTS(MAX_OUTPUTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .init_busy_o(init_busy),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res_in),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  fcl_queue #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop_i),
    .rdata_o(res_rdata),
    .empty_o(empty_o)
  );

  assign res_out           = res_t'(res_rdata);
  assign kind_o            = res_out.kind;
  assign index_o           = res_out.index;
  assign result_value_o    = res_out.value;
  assign weight_gradient_o = res_out.wgrad;
  assign bias_gradient_o   = res_out.bgrad;
  assign last_o            = res_out.last;

endmodule
